/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// trigger implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)

`endif

`endif

/* hdl/ede_pkg.sv */
// ----------------------------------------------------------------------------
// ede_pkg
// Shared types and constants of the edit distance engine
// ----------------------------------------------------------------------------
package ede_pkg;

	// longest target or candidate word, at most 63 so a row entry fits the result
	localparam int MAX_LEN = 32;

	localparam int SYM_W  = 8;
	localparam int LEN_W  = 6;
	localparam int DIST_W = 6;
	localparam int ADDR_W = $clog2(MAX_LEN);

	localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_FEED   = 2'd2,
		MODE_FINISH = 2'd3
	} mode_t;

	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [ADDR_W-1:0] addr_t;

endpackage

/* hdl/ede_item_if.sv */
// ----------------------------------------------------------------------------
// ede_item_if
// Input channel: one command with its byte per transaction
// ----------------------------------------------------------------------------
interface ede_item_if;

	logic          valid;
	logic          ready;
	ede_pkg::mode_t mode;
	ede_pkg::sym_t symbol;

	modport source (output valid, output mode, output symbol, input ready);
	modport sink (input valid, input mode, input symbol, output ready);

endinterface

/* hdl/ede_result_if.sv */
// ----------------------------------------------------------------------------
// ede_result_if
// Result channel: one distance and its drop flag per transaction
// ----------------------------------------------------------------------------
interface ede_result_if;

	logic           valid;
	logic           ready;
	ede_pkg::dist_t distance;
	logic           overflowed;

	modport source (output valid, output distance, output overflowed, input ready);
	modport sink (input valid, input distance, input overflowed, output ready);

endinterface

/* hdl/edit_distance_engine.sv */
// Sequencing: clear and append complete while idle; a candidate byte with a
// nonempty target sweeps the feed state, one row entry per cycle through
// the shared min/add unit and the row store; finish waits while the previous
// result is still unaccepted, registers it, then restores the row store.
// Throughput: one transaction at a time, ready only while the sequencer idles.
// Reset (arst_n low): empty target and candidate, flag clear, no result pending.
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein distance between a stored target word and a streamed candidate
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edit_distance_engine (
	input logic          clk,
	input logic          arst_n,
	ede_item_if.sink     item,
	ede_result_if.source result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_FIN,
		ST_RESTORE
	} state_t;

	state_t         state_q;
	ede_pkg::len_t  tlen_q;
	ede_pkg::len_t  cand_q;
	logic           drop_q;
	ede_pkg::len_t  j_q;
	ede_pkg::len_t  left_q;
	ede_pkg::len_t  diag_q;
	ede_pkg::sym_t  sym_q;
	logic           out_vld_q;
	ede_pkg::dist_t dist_q;
	logic           ovf_q;

	// memories: row entries 1..MAX_LEN at index j-1, entry zero is the candidate length
	ede_pkg::len_t  row_mem [ede_pkg::MAX_LEN];
	ede_pkg::sym_t  tgt_mem [ede_pkg::MAX_LEN];
	ede_pkg::len_t  rd_row_q;
	ede_pkg::sym_t  rd_tgt_q;

	logic           item_fire;
	logic           append_ok;
	ede_pkg::addr_t rd_addr;
	ede_pkg::addr_t tlen_m1;
	ede_pkg::addr_t j_m1;
	logic           row_we;
	ede_pkg::addr_t row_wa;
	ede_pkg::len_t  row_wd;
	ede_pkg::len_t  min_ab;
	ede_pkg::len_t  min_abc;
	ede_pkg::len_t  new_val;
	ede_pkg::len_t  tlen_d;
	ede_pkg::len_t  j_m1_full;
	ede_pkg::len_t  tlen_m1_full;

	assign item.ready      = (state_q == ST_IDLE);
	assign item_fire       = item.valid && item.ready;
	assign result.valid    = out_vld_q;
	assign result.distance = dist_q;
	assign result.overflowed = ovf_q;

	assign append_ok    = (cand_q == '0) && (tlen_q < ede_pkg::MAX_LEN_L);
	assign tlen_d       = tlen_q + 1'b1;
	assign j_m1_full    = j_q - 1'b1;
	assign tlen_m1_full = tlen_q - 1'b1;
	assign j_m1         = j_m1_full[ede_pkg::ADDR_W-1:0];
	assign tlen_m1      = tlen_m1_full[ede_pkg::ADDR_W-1:0];

	// shared cell update: match takes the diagonal, else 1 + min of three
	always_comb begin
		min_ab  = (rd_row_q < left_q) ? rd_row_q : left_q;
		min_abc = (diag_q < min_ab) ? diag_q : min_ab;
		new_val = (rd_tgt_q == sym_q) ? diag_q : (min_abc + 1'b1);
	end

	always_comb begin
		rd_addr = '0;
		row_we  = 1'b0;
		row_wa  = j_m1;
		row_wd  = new_val;
		case (state_q)
			ST_IDLE: begin
				// finish needs row[m] on the read register in the next cycle
				rd_addr = (item.mode == ede_pkg::MODE_FEED) ? '0 : tlen_m1;
				if (item_fire && item.mode == ede_pkg::MODE_APPEND && append_ok) begin
					row_we = 1'b1;
					row_wa = tlen_q[ede_pkg::ADDR_W-1:0];
					row_wd = tlen_d;
				end
			end
			ST_FEED: begin
				// prefetch entry j+1 while entry j is written
				rd_addr = j_q[ede_pkg::ADDR_W-1:0];
				row_we  = 1'b1;
			end
			ST_FIN: begin
				// keep row[m] on the read register while the result register is busy
				rd_addr = tlen_m1;
			end
			ST_RESTORE: begin
				row_we = 1'b1;
				row_wd = j_q;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wa] <= row_wd;
		end
		rd_row_q <= row_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (item_fire && item.mode == ede_pkg::MODE_APPEND && append_ok) begin
			tgt_mem[tlen_q[ede_pkg::ADDR_W-1:0]] <= item.symbol;
		end
		rd_tgt_q <= tgt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tlen_q    <= '0;
			cand_q    <= '0;
			drop_q    <= 1'b0;
			j_q       <= '0;
			left_q    <= '0;
			diag_q    <= '0;
			sym_q     <= '0;
			out_vld_q <= 1'b0;
			dist_q    <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_fire) begin
						case (item.mode)
							ede_pkg::MODE_CLEAR: begin
								tlen_q <= '0;
								cand_q <= '0;
								drop_q <= 1'b0;
							end
							ede_pkg::MODE_APPEND: begin
								if (append_ok) begin
									tlen_q <= tlen_d;
								end else begin
									drop_q <= 1'b1;
								end
							end
							ede_pkg::MODE_FEED: begin
								if (cand_q >= ede_pkg::MAX_LEN_L) begin
									drop_q <= 1'b1;
								end else begin
									cand_q <= cand_q + 1'b1;
									left_q <= cand_q + 1'b1;
									diag_q <= cand_q;
									sym_q  <= item.symbol;
									j_q    <= ede_pkg::len_t'(1);
									if (tlen_q != '0) begin
										state_q <= ST_FEED;
									end
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_FEED: begin
					left_q <= new_val;
					diag_q <= rd_row_q;
					j_q    <= j_q + 1'b1;
					if (j_q == tlen_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					// wait for the output register to free up
					if (!out_vld_q || result.ready) begin
						dist_q    <= (tlen_q == '0) ? cand_q : rd_row_q;
						ovf_q     <= drop_q;
						out_vld_q <= 1'b1;
						cand_q    <= '0;
						drop_q    <= 1'b0;
						j_q       <= ede_pkg::len_t'(1);
						state_q   <= (tlen_q == '0) ? ST_IDLE : ST_RESTORE;
					end
				end
				ST_RESTORE: begin
					j_q <= j_q + 1'b1;
					if (j_q == tlen_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_len_bound, clk, arst_n, (tlen_q <= ede_pkg::MAX_LEN_L) && (cand_q <= ede_pkg::MAX_LEN_L), "word length beyond limit")
	`ASSERT_ALWAYS(a_sweep_index, clk, arst_n, !(state_q == ST_FEED || state_q == ST_RESTORE) || (j_q >= ede_pkg::len_t'(1) && j_q <= tlen_q), "row sweep index out of target range")
	`ASSERT_NEXT(a_finish_seq, clk, arst_n, item_fire && item.mode == ede_pkg::MODE_FINISH, state_q == ST_FIN, "finish did not start result load")
	`ASSERT_ALWAYS(a_result_src, clk, arst_n, !$rose(out_vld_q) || $past(state_q == ST_FIN), "result raised outside finish")

endmodule
